@@ design/sector_cache_lru_controller_assert.svh @@
// Assertion macros used by the sequencer of the sector cache controller.
`ifndef SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH
`define SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define SCL_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define SCL_ASSERT_NORST(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define SCL_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)
`define SCL_ASSERT_NORST(lbl, clk_sig, prop, msg)
`endif

`endif

@@ design/scl_pkg.sv @@
// Shared types and constants of the sector cache controller.
package scl_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int IDX_W_DEFAULT = $clog2(SLOTS_DEFAULT);

  localparam int LBA_W        = 32;
  localparam int SLOT_FIELD_W = 4;
  localparam int ACTION_W     = 3;
  localparam int CMD_W        = 2;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_TUSER_W  = 5;
  localparam int OUT_PAD_W    = OUT_TDATA_W - LBA_W - SLOT_FIELD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SERVE  = 3'd0,
    ACT_FETCH  = 3'd1,
    ACT_WBACK  = 3'd2,
    ACT_PREAD  = 3'd3,
    ACT_PWRITE = 3'd4,
    ACT_WTHRU  = 3'd5,
    ACT_BFLUSH = 3'd6,
    ACT_STORE  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_VICT_RD,
    ST_WBACK,
    ST_FETCH,
    ST_SERVE,
    ST_PREAD,
    ST_PWRITE,
    ST_STORE,
    ST_WTHRU,
    ST_FL_RD,
    ST_FL_WB,
    ST_BFLUSH
  } state_t;

  typedef struct packed {
    logic set_valid;
    logic clr_valid;
    logic set_dirty;
    logic clr_dirty;
    logic touch;
  } slot_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tag_ctl_t;

endpackage

@@ design/scl_tag_mem.sv @@
// Tag memory with registered read port and the shared tag comparator.
module scl_tag_mem #(
  parameter int SLOTS = scl_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = scl_pkg::IDX_W_DEFAULT
) (
  input  logic                     clk,
  input  scl_pkg::tag_ctl_t        ctl,
  input  logic [IDX_W-1:0]         rd_addr,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [scl_pkg::LBA_W-1:0] wr_data,
  input  logic [scl_pkg::LBA_W-1:0] key,
  output logic [scl_pkg::LBA_W-1:0] rd_data,
  output logic                     match
);

  logic [scl_pkg::LBA_W-1:0] tag_mem_r [SLOTS];
  logic [scl_pkg::LBA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      tag_mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= tag_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign match   = (rd_data_r == key);

endmodule

@@ design/scl_seq.sv @@
// Sequencer, slot state, scan bookkeeping and result register of the controller.
`include "sector_cache_lru_controller_assert.svh"

module scl_seq #(
  parameter int SLOTS = scl_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = scl_pkg::IDX_W_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scl_pkg::LBA_W-1:0]      in_tdata,
  input  logic                           in_tlast,
  input  logic [scl_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [scl_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic [scl_pkg::OUT_TUSER_W-1:0] out_tuser,
  output scl_pkg::tag_ctl_t              tag_ctl,
  output logic [IDX_W-1:0]               tag_rd_addr,
  output logic [IDX_W-1:0]               tag_wr_addr,
  output logic [scl_pkg::LBA_W-1:0]      tag_key,
  input  logic [scl_pkg::LBA_W-1:0]      tag_rd_data,
  input  logic                           tag_match
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(SLOTS - 1);

  scl_pkg::state_t state_r, state_nxt;

  logic                      wt_mode_r;
  scl_pkg::cmd_t             cmd_r;
  logic [scl_pkg::LBA_W-1:0] lba_r;
  logic                      bypass_r;
  logic                      req_end_r;

  logic [SLOTS-1:0] slot_valid_r;
  logic [SLOTS-1:0] slot_dirty_r;
  logic [IDX_W-1:0] lru_rank_r [SLOTS];

  logic [IDX_W-1:0] scan_idx_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] hit_rank_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [IDX_W-1:0] free_rank_r;
  logic [IDX_W-1:0] lru_idx_r;
  logic             lru_dirty_r;
  logic [IDX_W-1:0] tgt_r;
  logic [IDX_W-1:0] tgt_rank_r;

  logic                            out_tvalid_r;
  scl_pkg::action_t                out_action_r;
  logic [scl_pkg::SLOT_FIELD_W-1:0] out_slot_r;
  logic [scl_pkg::LBA_W-1:0]       out_lba_r;
  logic                            out_hit_r;
  logic                            out_end_r;
  logic                            out_last_r;

  logic accept;
  logic out_free;
  logic wb_needed;
  logic fl_dirty;
  logic [IDX_W-1:0] alloc_idx;

  logic                      emit;
  scl_pkg::action_t          e_action;
  logic [IDX_W-1:0]          e_slot;
  logic [scl_pkg::LBA_W-1:0] e_lba;
  logic                      e_hit;
  logic                      e_last;
  scl_pkg::slot_op_t         op;
  logic [IDX_W-1:0]          op_idx;
  logic                      idx_inc;
  logic                      scan_issue;

  assign in_tready = (state_r == scl_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign wb_needed = !free_r && lru_dirty_r;
  assign alloc_idx = free_r ? free_idx_r : lru_idx_r;
  assign fl_dirty  = slot_valid_r[scan_idx_r] && slot_dirty_r[scan_idx_r];

  assign tag_wr_addr = tgt_r;
  assign tag_key     = lba_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scl_pkg::ST_IDLE: begin
        if (accept) begin
          case (scl_pkg::cmd_t'(in_tuser[scl_pkg::CMD_W-1:0]))
            scl_pkg::CMD_READ:  state_nxt = scl_pkg::ST_SCAN;
            scl_pkg::CMD_WRITE: state_nxt = scl_pkg::ST_SCAN;
            scl_pkg::CMD_FLUSH: state_nxt = scl_pkg::ST_FL_RD;
            default:            state_nxt = scl_pkg::ST_IDLE;
          endcase
        end
      end
      scl_pkg::ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = scl_pkg::ST_DRAIN;
        end
      end
      scl_pkg::ST_DRAIN: state_nxt = scl_pkg::ST_DECIDE;
      scl_pkg::ST_DECIDE: begin
        if (cmd_r == scl_pkg::CMD_READ) begin
          if (hit_r) begin
            state_nxt = scl_pkg::ST_SERVE;
          end else if (bypass_r) begin
            state_nxt = scl_pkg::ST_PREAD;
          end else if (wb_needed) begin
            state_nxt = scl_pkg::ST_VICT_RD;
          end else begin
            state_nxt = scl_pkg::ST_FETCH;
          end
        end else begin
          if (bypass_r) begin
            state_nxt = scl_pkg::ST_PWRITE;
          end else if (hit_r) begin
            state_nxt = scl_pkg::ST_STORE;
          end else if (wb_needed) begin
            state_nxt = scl_pkg::ST_VICT_RD;
          end else begin
            state_nxt = scl_pkg::ST_STORE;
          end
        end
      end
      scl_pkg::ST_VICT_RD: state_nxt = scl_pkg::ST_WBACK;
      scl_pkg::ST_WBACK: begin
        if (out_free) begin
          state_nxt = (cmd_r == scl_pkg::CMD_READ) ? scl_pkg::ST_FETCH : scl_pkg::ST_STORE;
        end
      end
      scl_pkg::ST_FETCH: begin
        if (out_free) begin
          state_nxt = scl_pkg::ST_SERVE;
        end
      end
      scl_pkg::ST_STORE: begin
        if (out_free) begin
          state_nxt = wt_mode_r ? scl_pkg::ST_WTHRU : scl_pkg::ST_IDLE;
        end
      end
      scl_pkg::ST_SERVE, scl_pkg::ST_PREAD, scl_pkg::ST_PWRITE,
      scl_pkg::ST_WTHRU, scl_pkg::ST_BFLUSH: begin
        if (out_free) begin
          state_nxt = scl_pkg::ST_IDLE;
        end
      end
      scl_pkg::ST_FL_RD: begin
        if (fl_dirty) begin
          state_nxt = scl_pkg::ST_FL_WB;
        end else if (scan_idx_r == LAST_IDX) begin
          state_nxt = scl_pkg::ST_BFLUSH;
        end
      end
      scl_pkg::ST_FL_WB: begin
        if (out_free) begin
          state_nxt = (scan_idx_r == LAST_IDX) ? scl_pkg::ST_BFLUSH : scl_pkg::ST_FL_RD;
        end
      end
      default: state_nxt = scl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    e_action    = scl_pkg::ACT_SERVE;
    e_slot      = tgt_r;
    e_lba       = lba_r;
    e_hit       = hit_r;
    e_last      = 1'b0;
    op          = '0;
    op_idx      = tgt_r;
    tag_ctl     = '0;
    tag_rd_addr = scan_idx_r;
    idx_inc     = 1'b0;
    scan_issue  = 1'b0;
    case (state_r)
      scl_pkg::ST_SCAN: begin
        tag_ctl.rd_en = 1'b1;
        idx_inc       = 1'b1;
        scan_issue    = 1'b1;
      end
      scl_pkg::ST_VICT_RD: begin
        tag_ctl.rd_en = 1'b1;
        tag_rd_addr   = tgt_r;
      end
      scl_pkg::ST_WBACK: begin
        if (out_free) begin
          emit         = 1'b1;
          e_action     = scl_pkg::ACT_WBACK;
          e_lba        = tag_rd_data;
          e_hit        = 1'b0;
          op.clr_dirty = 1'b1;
        end
      end
      scl_pkg::ST_FETCH: begin
        if (out_free) begin
          emit          = 1'b1;
          e_action      = scl_pkg::ACT_FETCH;
          op.set_valid  = 1'b1;
          op.clr_dirty  = 1'b1;
          tag_ctl.wr_en = 1'b1;
        end
      end
      scl_pkg::ST_SERVE: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = scl_pkg::ACT_SERVE;
          e_last   = 1'b1;
          op.touch = 1'b1;
        end
      end
      scl_pkg::ST_PREAD: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = scl_pkg::ACT_PREAD;
          e_slot   = '0;
          e_hit    = 1'b0;
          e_last   = 1'b1;
        end
      end
      scl_pkg::ST_PWRITE: begin
        if (out_free) begin
          emit         = 1'b1;
          e_action     = scl_pkg::ACT_PWRITE;
          e_last       = 1'b1;
          op.clr_valid = hit_r;
          op.clr_dirty = hit_r;
        end
      end
      scl_pkg::ST_STORE: begin
        if (out_free) begin
          emit          = 1'b1;
          e_action      = scl_pkg::ACT_STORE;
          e_last        = !wt_mode_r;
          tag_ctl.wr_en = !hit_r;
          op.set_valid  = !hit_r;
          op.clr_dirty  = wt_mode_r;
          op.set_dirty  = !wt_mode_r;
          op.touch      = !wt_mode_r;
        end
      end
      scl_pkg::ST_WTHRU: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = scl_pkg::ACT_WTHRU;
          e_last   = 1'b1;
          op.touch = 1'b1;
        end
      end
      scl_pkg::ST_FL_RD: begin
        if (fl_dirty) begin
          tag_ctl.rd_en = 1'b1;
        end else begin
          idx_inc = 1'b1;
        end
      end
      scl_pkg::ST_FL_WB: begin
        if (out_free) begin
          emit         = 1'b1;
          e_action     = scl_pkg::ACT_WBACK;
          e_slot       = scan_idx_r;
          e_lba        = tag_rd_data;
          e_hit        = 1'b0;
          op.clr_dirty = 1'b1;
          op_idx       = scan_idx_r;
          idx_inc      = 1'b1;
        end
      end
      scl_pkg::ST_BFLUSH: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = scl_pkg::ACT_BFLUSH;
          e_slot   = '0;
          e_lba    = '0;
          e_hit    = 1'b0;
          e_last   = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scl_pkg::ST_IDLE;
      wt_mode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        wt_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= scl_pkg::cmd_t'(in_tuser[scl_pkg::CMD_W-1:0]);
      lba_r     <= in_tdata;
      bypass_r  <= in_tuser[scl_pkg::CMD_W];
      req_end_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      pend_r <= scan_issue;
      if (accept) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else begin
        if (idx_inc) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (pend_r) begin
          if (slot_valid_r[pend_idx_r] && tag_match) begin
            hit_r <= 1'b1;
          end
          if (!slot_valid_r[pend_idx_r]) begin
            free_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= scan_idx_r;
    if (pend_r) begin
      if (slot_valid_r[pend_idx_r] && tag_match) begin
        hit_idx_r  <= pend_idx_r;
        hit_rank_r <= lru_rank_r[pend_idx_r];
      end
      if (!slot_valid_r[pend_idx_r] && !free_r) begin
        free_idx_r  <= pend_idx_r;
        free_rank_r <= lru_rank_r[pend_idx_r];
      end
      if (lru_rank_r[pend_idx_r] == RANK_MAX) begin
        lru_idx_r   <= pend_idx_r;
        lru_dirty_r <= slot_dirty_r[pend_idx_r];
      end
    end
    if (state_r == scl_pkg::ST_DECIDE) begin
      if (hit_r) begin
        tgt_r      <= hit_idx_r;
        tgt_rank_r <= hit_rank_r;
      end else if (bypass_r && (cmd_r == scl_pkg::CMD_WRITE)) begin
        tgt_r      <= '0;
        tgt_rank_r <= RANK_MAX;
      end else begin
        tgt_r      <= alloc_idx;
        tgt_rank_r <= free_r ? free_rank_r : RANK_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_dirty_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        lru_rank_r[i] <= IDX_W'(i);
      end
    end else begin
      if (op.set_valid) begin
        slot_valid_r[op_idx] <= 1'b1;
      end
      if (op.clr_valid) begin
        slot_valid_r[op_idx] <= 1'b0;
      end
      if (op.set_dirty) begin
        slot_dirty_r[op_idx] <= 1'b1;
      end
      if (op.clr_dirty) begin
        slot_dirty_r[op_idx] <= 1'b0;
      end
      if (op.touch) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IDX_W'(i) == tgt_r) begin
            lru_rank_r[i] <= '0;
          end else if (lru_rank_r[i] < tgt_rank_r) begin
            lru_rank_r[i] <= lru_rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r <= e_action;
      out_slot_r   <= scl_pkg::SLOT_FIELD_W'(e_slot);
      out_lba_r    <= e_lba;
      out_hit_r    <= e_hit;
      out_end_r    <= req_end_r;
      out_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{scl_pkg::OUT_PAD_W{1'b0}}, out_lba_r, out_slot_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_end_r, out_hit_r, out_action_r};

  `SCL_ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready && (in_tuser[1:0] != scl_pkg::CMD_NONE)) |=> !in_tready, "controller ready right after taking an item")
  `SCL_ASSERT_CLK(a_serve_valid, clk, rst_n, (state_r == scl_pkg::ST_SERVE) |-> slot_valid_r[tgt_r], "serving a slot that is not valid")
  `SCL_ASSERT_CLK(a_flush_dirty, clk, rst_n, (state_r == scl_pkg::ST_FL_WB) |-> (slot_valid_r[scan_idx_r] && slot_dirty_r[scan_idx_r]), "flush writes back a clean slot")
  `SCL_ASSERT_CLK(a_hit_valid, clk, rst_n, (state_r == scl_pkg::ST_DECIDE && hit_r) |-> slot_valid_r[hit_idx_r], "hit recorded on an invalid slot")
  `SCL_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> (state_r == scl_pkg::ST_IDLE && !out_tvalid_r), "reset leaves the controller busy")

endmodule

@@ design/sector_cache_lru_controller.sv @@
// Top level of the fully associative LRU sector cache tag and policy controller.
// Each request is handled alone: a read or write scans the tag RAM one slot per
// cycle through its single read port, so it takes SLOTS + 3 cycles before the first
// command, then one cycle per command item, plus one more cycle when a dirty
// victim tag has to be read back. A flush takes one cycle per slot, one more per
// dirty slot, and one for the final backing flush. Back-pressure on the result
// side adds to these figures. in_tready is high only while the controller is idle.
module sector_cache_lru_controller #(
  parameter int SLOTS = scl_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,   // write_through_mode
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [scl_pkg::LBA_W-1:0]       in_tdata,    // lba
  input  logic                            in_tlast,    // last_of_request
  input  logic [scl_pkg::IN_TUSER_W-1:0]  in_tuser,    // command[1:0], bypass[2]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [scl_pkg::OUT_TDATA_W-1:0] out_tdata,   // slot[3:0], backing_lba[35:4]
  output logic                            out_tlast,   // last_result
  output logic [scl_pkg::OUT_TUSER_W-1:0] out_tuser    // action[2:0], hit[3], request_end[4]
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  scl_pkg::tag_ctl_t         tag_ctl;
  logic [IDX_W-1:0]          tag_rd_addr;
  logic [IDX_W-1:0]          tag_wr_addr;
  logic [scl_pkg::LBA_W-1:0] tag_key;
  logic [scl_pkg::LBA_W-1:0] tag_rd_data;
  logic                      tag_match;

  scl_seq #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .tag_ctl     (tag_ctl),
    .tag_rd_addr (tag_rd_addr),
    .tag_wr_addr (tag_wr_addr),
    .tag_key     (tag_key),
    .tag_rd_data (tag_rd_data),
    .tag_match   (tag_match)
  );

  scl_tag_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_tag_mem (
    .clk     (clk),
    .ctl     (tag_ctl),
    .rd_addr (tag_rd_addr),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_key),
    .key     (tag_key),
    .rd_data (tag_rd_data),
    .match   (tag_match)
  );

endmodule
